FILE: hdl/dtp_pkg.sv
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared constants and helpers for the date and time text parser: the line
// layout, the separator characters and the range limits of the six fields.
// ----------------------------------------------------------------------------
`default_nettype none

package dtp_pkg;

   // line layout
   localparam int unsigned POS_W = 5;
   localparam logic [POS_W-1:0] LINE_LEN   = 5'd19;
   localparam logic [POS_W-1:0] POS_STOP   = 5'd20;
   localparam logic [POS_W-1:0] LAST_POS   = 5'd18;
   localparam logic [POS_W-1:0] POS_DASH_A = 5'd4;
   localparam logic [POS_W-1:0] POS_DASH_B = 5'd7;
   localparam logic [POS_W-1:0] POS_SPACE  = 5'd10;
   localparam logic [POS_W-1:0] POS_COL_A  = 5'd13;
   localparam logic [POS_W-1:0] POS_COL_B  = 5'd16;
   // last position of each numeric field
   localparam logic [POS_W-1:0] YEAR_END   = 5'd3;
   localparam logic [POS_W-1:0] MONTH_END  = 5'd6;
   localparam logic [POS_W-1:0] DAY_END    = 5'd9;
   localparam logic [POS_W-1:0] HOUR_END   = 5'd12;
   localparam logic [POS_W-1:0] MINUTE_END = 5'd15;

   // characters
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // field widths and limits
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned FIELD_W = 7;
   localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd2000;
   localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd2099;
   localparam logic [FIELD_W-1:0] MONTH_MAX  = 7'd12;
   localparam logic [FIELD_W-1:0] DAY_MAX    = 7'd31;
   localparam logic [FIELD_W-1:0] HOUR_MAX   = 7'd23;
   localparam logic [FIELD_W-1:0] MINSEC_MAX = 7'd59;

   localparam int unsigned RSP_DATA_W = 56;

   // acc * 10 + digit, wrapped to the year width
   function automatic logic [YEAR_W-1:0] acc_digit(input logic [YEAR_W-1:0] acc,
                                                   input logic [3:0] dig);
      logic [YEAR_W-1:0] sum;
      sum = {acc[YEAR_W-4:0], 3'b000} + {acc[YEAR_W-2:0], 1'b0}
            + {{(YEAR_W-4){1'b0}}, dig};
      return sum;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/datetime_text_parser.sv
// ----------------------------------------------------------------------------
// datetime_text_parser
// Checks a text line of the form YYYY-MM-DD HH:MM:SS, one character per
// transaction, and returns one result transaction per line.
// ----------------------------------------------------------------------------
// Result: registered; it appears in the cycle after the character marked tlast.
// Throughput: one character per cycle; the only stall is a held result with
// rsp_tready low, which blocks further characters through the result register.
// Reset: synchronous, active high; clears the position counter, the
// accumulators and the result valid flag, and sets the layout flag.
`default_nettype none

module datetime_text_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   input  wire logic        req_tlast,   // end_of_line
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [13:0] year, [20:14] month, [27:21] day, [34:28] hour, [41:35] minute,
   // [48:42] second, [55:49] zero
   output      logic [dtp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output      logic        rsp_tuser    // valid_res
);

   logic [dtp_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                        layout_ff, layout_in;
   logic [dtp_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic [dtp_pkg::FIELD_W-1:0] month_ff, month_in, day_ff, day_in;
   logic [dtp_pkg::FIELD_W-1:0] hour_ff, hour_in, minute_ff, minute_in;
   logic [dtp_pkg::FIELD_W-1:0] second_ff, second_in;

   logic                        out_valid_ff, out_valid_in;
   logic                        out_ok_ff;
   logic [dtp_pkg::YEAR_W-1:0]  out_year_ff;
   logic [dtp_pkg::FIELD_W-1:0] out_month_ff, out_day_ff, out_hour_ff;
   logic [dtp_pkg::FIELD_W-1:0] out_minute_ff, out_second_ff;

   logic                        accept;
   logic                        is_digit, is_sep_pos, sep_match, fault, take;
   logic [3:0]                  dig;
   logic [dtp_pkg::YEAR_W-1:0]  acc_sel, acc_new;
   logic                        ok;

   assign req_tready = rsp_tready | ~out_valid_ff;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      is_digit = (req_tdata >= dtp_pkg::CHAR_ZERO) && (req_tdata <= dtp_pkg::CHAR_NINE);
      dig      = req_tdata[3:0];

      is_sep_pos = 1'b1;
      sep_match  = 1'b0;
      case (pos_ff)
         dtp_pkg::POS_DASH_A, dtp_pkg::POS_DASH_B: sep_match = (req_tdata == dtp_pkg::CHAR_DASH);
         dtp_pkg::POS_SPACE:                       sep_match = (req_tdata == dtp_pkg::CHAR_SPACE);
         dtp_pkg::POS_COL_A, dtp_pkg::POS_COL_B:   sep_match = (req_tdata == dtp_pkg::CHAR_COLON);
         default:                                  is_sep_pos = 1'b0;
      endcase

      if (pos_ff >= dtp_pkg::LINE_LEN) begin
         fault = 1'b1;
         take  = 1'b0;
      end else if (is_sep_pos) begin
         fault = ~sep_match;
         take  = 1'b0;
      end else begin
         fault = ~is_digit;
         take  = is_digit;
      end

      // pick the accumulator that this position feeds
      if (pos_ff <= dtp_pkg::YEAR_END) begin
         acc_sel = year_ff;
      end else if (pos_ff <= dtp_pkg::MONTH_END) begin
         acc_sel = {{(dtp_pkg::YEAR_W-dtp_pkg::FIELD_W){1'b0}}, month_ff};
      end else if (pos_ff <= dtp_pkg::DAY_END) begin
         acc_sel = {{(dtp_pkg::YEAR_W-dtp_pkg::FIELD_W){1'b0}}, day_ff};
      end else if (pos_ff <= dtp_pkg::HOUR_END) begin
         acc_sel = {{(dtp_pkg::YEAR_W-dtp_pkg::FIELD_W){1'b0}}, hour_ff};
      end else if (pos_ff <= dtp_pkg::MINUTE_END) begin
         acc_sel = {{(dtp_pkg::YEAR_W-dtp_pkg::FIELD_W){1'b0}}, minute_ff};
      end else begin
         acc_sel = {{(dtp_pkg::YEAR_W-dtp_pkg::FIELD_W){1'b0}}, second_ff};
      end
      acc_new = dtp_pkg::acc_digit(acc_sel, dig);

      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      if (take) begin
         if (pos_ff <= dtp_pkg::YEAR_END) begin
            year_in = acc_new;
         end else if (pos_ff <= dtp_pkg::MONTH_END) begin
            month_in = acc_new[dtp_pkg::FIELD_W-1:0];
         end else if (pos_ff <= dtp_pkg::DAY_END) begin
            day_in = acc_new[dtp_pkg::FIELD_W-1:0];
         end else if (pos_ff <= dtp_pkg::HOUR_END) begin
            hour_in = acc_new[dtp_pkg::FIELD_W-1:0];
         end else if (pos_ff <= dtp_pkg::MINUTE_END) begin
            minute_in = acc_new[dtp_pkg::FIELD_W-1:0];
         end else begin
            second_in = acc_new[dtp_pkg::FIELD_W-1:0];
         end
      end

      layout_in = layout_ff & ~fault;
      pos_in    = (pos_ff >= dtp_pkg::LAST_POS + 5'd1) ? dtp_pkg::POS_STOP : pos_ff + 5'd1;

      ok = layout_in && (pos_ff == dtp_pkg::LAST_POS)
           && (year_in >= dtp_pkg::YEAR_MIN) && (year_in <= dtp_pkg::YEAR_MAX)
           && (month_in != '0) && (month_in <= dtp_pkg::MONTH_MAX)
           && (day_in != '0) && (day_in <= dtp_pkg::DAY_MAX)
           && (hour_in <= dtp_pkg::HOUR_MAX)
           && (minute_in <= dtp_pkg::MINSEC_MAX)
           && (second_in <= dtp_pkg::MINSEC_MAX);

      // hold the result until taken, load a new one on the end of a line
      out_valid_in = out_valid_ff & ~rsp_tready;
      if (accept && req_tlast) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         layout_ff <= 1'b1;
         year_ff   <= '0;
         month_ff  <= '0;
         day_ff    <= '0;
         hour_ff   <= '0;
         minute_ff <= '0;
         second_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (accept) begin
            if (req_tlast) begin
               // clear for the next line
               pos_ff    <= '0;
               layout_ff <= 1'b1;
               year_ff   <= '0;
               month_ff  <= '0;
               day_ff    <= '0;
               hour_ff   <= '0;
               minute_ff <= '0;
               second_ff <= '0;
            end else begin
               pos_ff    <= pos_in;
               layout_ff <= layout_in;
               year_ff   <= year_in;
               month_ff  <= month_in;
               day_ff    <= day_in;
               hour_ff   <= hour_in;
               minute_ff <= minute_in;
               second_ff <= second_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tlast) begin
         out_ok_ff     <= ok;
         out_year_ff   <= ok ? year_in   : '0;
         out_month_ff  <= ok ? month_in  : '0;
         out_day_ff    <= ok ? day_in    : '0;
         out_hour_ff   <= ok ? hour_in   : '0;
         out_minute_ff <= ok ? minute_in : '0;
         out_second_ff <= ok ? second_in : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ok_ff;
   assign rsp_tdata  = {7'd0, out_second_ff, out_minute_ff, out_hour_ff,
                        out_day_ff, out_month_ff, out_year_ff};

endmodule

`default_nettype wire

FILE: verif/datetime_text_parser_test.sv
// ----------------------------------------------------------------------------
// datetime_text_parser_test
// Streams text lines into the date and time parser one character per
// transaction. A local model of the line checker predicts each result, and a
// monitor compares every result transaction field by field. Directed lines
// cover the field limits, layout faults and line lengths. Random lines follow,
// mostly well-formed, with random gaps and back-pressure on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module datetime_text_parser_test;

   typedef logic [7:0] line_type[$];

   typedef struct {
      bit                                valid;
      logic [dtp_pkg::YEAR_W-1:0]        year;
      logic [dtp_pkg::FIELD_W-1:0]       month;
      logic [dtp_pkg::FIELD_W-1:0]       day;
      logic [dtp_pkg::FIELD_W-1:0]       hour;
      logic [dtp_pkg::FIELD_W-1:0]       minute;
      logic [dtp_pkg::FIELD_W-1:0]       second;
   } date_rec_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [7:0]                     req_tdata;   // [7:0] char_code
   logic                           req_tlast;   // end_of_line
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   // [13:0] year, [20:14] month, [27:21] day, [34:28] hour, [41:35] minute,
   // [48:42] second, [55:49] zero
   logic [dtp_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;   // valid_res

   // line checker state
   logic [dtp_pkg::POS_W-1:0]      line_pos;
   bit                             line_ok;
   logic [dtp_pkg::YEAR_W-1:0]     year_sum;
   logic [dtp_pkg::FIELD_W-1:0]    month_sum, day_sum, hour_sum, minute_sum, second_sum;

   date_rec_type                   pending_dates[$];
   int unsigned                    fail_count;
   int unsigned                    chars_sent;
   bit                             gaps_on;

   datetime_text_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end

   task automatic clear_line();
      line_pos   = '0;
      line_ok    = 1'b1;
      year_sum   = '0;
      month_sum  = '0;
      day_sum    = '0;
      hour_sum   = '0;
      minute_sum = '0;
      second_sum = '0;
   endtask

   // Advance the line checker by one character; queue a result on end of line.
   task automatic track_char(input logic [7:0] c, input bit last);
      date_rec_type rec;
      logic [3:0]   dig;
      bit           is_digit;
      bit           ok;
      is_digit = (c >= dtp_pkg::CHAR_ZERO) && (c <= dtp_pkg::CHAR_NINE);
      dig      = 4'(c - dtp_pkg::CHAR_ZERO);
      if (line_pos >= dtp_pkg::LINE_LEN) begin
         line_ok = 1'b0;
      end else if (line_pos == dtp_pkg::POS_DASH_A || line_pos == dtp_pkg::POS_DASH_B) begin
         if (c != dtp_pkg::CHAR_DASH) line_ok = 1'b0;
      end else if (line_pos == dtp_pkg::POS_SPACE) begin
         if (c != dtp_pkg::CHAR_SPACE) line_ok = 1'b0;
      end else if (line_pos == dtp_pkg::POS_COL_A || line_pos == dtp_pkg::POS_COL_B) begin
         if (c != dtp_pkg::CHAR_COLON) line_ok = 1'b0;
      end else if (!is_digit) begin
         line_ok = 1'b0;
      end else if (line_pos <= dtp_pkg::YEAR_END) begin
         year_sum = 14'(year_sum * 10 + dig);
      end else if (line_pos <= dtp_pkg::MONTH_END) begin
         month_sum = 7'(month_sum * 10 + dig);
      end else if (line_pos <= dtp_pkg::DAY_END) begin
         day_sum = 7'(day_sum * 10 + dig);
      end else if (line_pos <= dtp_pkg::HOUR_END) begin
         hour_sum = 7'(hour_sum * 10 + dig);
      end else if (line_pos <= dtp_pkg::MINUTE_END) begin
         minute_sum = 7'(minute_sum * 10 + dig);
      end else begin
         second_sum = 7'(second_sum * 10 + dig);
      end

      if (!last) begin
         line_pos = (line_pos + 5'd1 >= dtp_pkg::POS_STOP) ? dtp_pkg::POS_STOP
                                                           : line_pos + 5'd1;
      end else begin
         ok = line_ok && (line_pos == dtp_pkg::LAST_POS)
              && year_sum >= dtp_pkg::YEAR_MIN && year_sum <= dtp_pkg::YEAR_MAX
              && month_sum >= 1 && month_sum <= dtp_pkg::MONTH_MAX
              && day_sum >= 1 && day_sum <= dtp_pkg::DAY_MAX
              && hour_sum <= dtp_pkg::HOUR_MAX && minute_sum <= dtp_pkg::MINSEC_MAX
              && second_sum <= dtp_pkg::MINSEC_MAX;
         rec.valid  = ok;
         rec.year   = ok ? year_sum : '0;
         rec.month  = ok ? month_sum : '0;
         rec.day    = ok ? day_sum : '0;
         rec.hour   = ok ? hour_sum : '0;
         rec.minute = ok ? minute_sum : '0;
         rec.second = ok ? second_sum : '0;
         pending_dates.push_back(rec);
         clear_line();
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // Predict on each accepted character, check each accepted result.
   always @(posedge clock) begin
      date_rec_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) track_char(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_dates.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none actual tuser=%0b tdata=%h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = pending_dates.pop_front();
               check_field("valid_res", 32'(want.valid), 32'(rsp_tuser));
               check_field("year", 32'(want.year), 32'(rsp_tdata[13:0]));
               check_field("month", 32'(want.month), 32'(rsp_tdata[20:14]));
               check_field("day", 32'(want.day), 32'(rsp_tdata[27:21]));
               check_field("hour", 32'(want.hour), 32'(rsp_tdata[34:28]));
               check_field("minute", 32'(want.minute), 32'(rsp_tdata[41:35]));
               check_field("second", 32'(want.second), 32'(rsp_tdata[48:42]));
            end
         end
      end
   end

   // Result side: ready runs broken by stall bursts while gaps are enabled.
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(negedge clock);
         if (gaps_on) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
      end
   end

   // Leaves tvalid high so that a following character goes out back to back.
   task automatic send_char(input logic [7:0] c, input bit last);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      chars_sent++;
   endtask

   task automatic send_line(input line_type chars);
      foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
   endtask

   // Drop tvalid and hold until every predicted result has come back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_dates.size() != 0) @(negedge clock);
   endtask

   function automatic line_type date_chars(int unsigned y, int unsigned mo, int unsigned d,
                                           int unsigned h, int unsigned mi, int unsigned s);
      string    txt;
      line_type q;
      txt = $sformatf("%04d-%02d-%02d %02d:%02d:%02d", y, mo, d, h, mi, s);
      for (int i = 0; i < txt.len(); i++) q.push_back(txt[i]);
      return q;
   endfunction

   task automatic send_with_char(input line_type base, input logic [dtp_pkg::POS_W-1:0] pos,
                                 input logic [7:0] c);
      line_type q;
      q      = base;
      q[pos] = c;
      send_line(q);
   endtask

   task automatic test_good_dates();
      send_line(date_chars(2000, 1, 1, 0, 0, 0));
      send_line(date_chars(2099, 12, 31, 23, 59, 59));
      // day is not checked against the month
      send_line(date_chars(2024, 2, 31, 12, 34, 56));
      wait_idle();
   endtask

   task automatic test_field_ranges();
      send_line(date_chars(1999, 6, 15, 12, 30, 30));
      send_line(date_chars(2100, 6, 15, 12, 30, 30));
      send_line(date_chars(2050, 0, 15, 12, 30, 30));
      send_line(date_chars(2050, 13, 15, 12, 30, 30));
      send_line(date_chars(2050, 6, 0, 12, 30, 30));
      send_line(date_chars(2050, 6, 32, 12, 30, 30));
      send_line(date_chars(2050, 6, 15, 24, 30, 30));
      send_line(date_chars(2050, 6, 15, 12, 60, 30));
      send_line(date_chars(2050, 6, 15, 12, 30, 60));
      wait_idle();
   endtask

   task automatic test_bad_layout();
      line_type base;
      base = date_chars(2050, 6, 15, 12, 30, 45);
      send_with_char(base, dtp_pkg::POS_DASH_A, "/");
      send_with_char(base, dtp_pkg::POS_DASH_B, dtp_pkg::CHAR_ZERO);
      send_with_char(base, dtp_pkg::POS_SPACE, "T");
      send_with_char(base, dtp_pkg::POS_COL_A, ".");
      send_with_char(base, dtp_pkg::POS_COL_B, dtp_pkg::CHAR_DASH);
      send_with_char(base, 5'd0, "A");
      send_with_char(base, dtp_pkg::LAST_POS, 8'h00);
      send_with_char(base, 5'd11, 8'hFF);
      send_with_char(base, 5'd2, 8'h80);
      wait_idle();
   endtask

   task automatic test_line_length();
      line_type q;
      q = date_chars(2050, 6, 15, 12, 30, 45);
      send_line(q[0:0]);
      send_line(q[0:17]);
      q.push_back(dtp_pkg::CHAR_ZERO);
      send_line(q);
      // run the position counter into its stop value
      repeat (5) q.push_back(dtp_pkg::CHAR_NINE);
      send_line(q);
      wait_idle();
   endtask

   task automatic test_random_lines();
      line_type    q;
      int unsigned start;
      int unsigned pick;
      int unsigned y;
      int unsigned n;
      bit          paused;
      start  = chars_sent;
      paused = 1'b0;
      while (chars_sent - start < 790) begin
         if (!paused && chars_sent - start >= 380) begin
            wait_idle();
            paused = 1'b1;
         end
         if (chars_sent - start >= 660) gaps_on = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            q = date_chars($urandom_range(2000, 2099), $urandom_range(1, 12),
                           $urandom_range(1, 31), $urandom_range(0, 23),
                           $urandom_range(0, 59), $urandom_range(0, 59));
         end else if (pick < 70) begin
            case ($urandom_range(0, 4))
               0: y = 1999;
               1: y = 2000;
               2: y = 2099;
               3: y = 2100;
               default: y = $urandom_range(0, 9999);
            endcase
            q = date_chars(y, $urandom_range(0, 99), $urandom_range(0, 99),
                           $urandom_range(0, 99), $urandom_range(0, 99),
                           $urandom_range(0, 99));
         end else if (pick < 82) begin
            q = date_chars($urandom_range(2000, 2099), $urandom_range(1, 12),
                           $urandom_range(1, 31), $urandom_range(0, 23),
                           $urandom_range(0, 59), $urandom_range(0, 59));
            q[$urandom_range(0, 18)] = 8'($urandom_range(0, 255));
         end else if (pick < 92) begin
            q = date_chars($urandom_range(2000, 2099), $urandom_range(1, 12),
                           $urandom_range(1, 31), $urandom_range(0, 23),
                           $urandom_range(0, 59), $urandom_range(0, 59));
            if ($urandom_range(0, 1)) begin
               n = $urandom_range(1, 18);
               q = q[0:n-1];
            end else begin
               repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
            end
         end else begin
            q.delete();
            repeat ($urandom_range(1, 24)) q.push_back(8'($urandom_range(0, 255)));
         end
         send_line(q);
      end
      wait_idle();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      gaps_on    = 1'b1;
      fail_count = 0;
      chars_sent = 0;
      clear_line();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_good_dates();
      test_field_ranges();
      test_bad_layout();
      test_line_length();
      test_random_lines();

      // let any stray result show up
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/dtp_pkg.sv
hdl/datetime_text_parser.sv
verif/datetime_text_parser_test.sv
